### sv/ihts_pkg.sv
// Shared constants, types and fixed-point helper functions of the heat solver.
`timescale 1ns / 1ps
`default_nettype none

package ihts_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int DATA_W     = 32;
    localparam int SHORT_GRID = 4;

    localparam logic signed [DATA_W-1:0] ONE_Q = 32'sd65536;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_METHOD   = 2'd0;
    localparam logic [1:0] CFG_RATIO    = 2'd1;
    localparam logic [1:0] CFG_BOUNDARY = 2'd2;
    localparam logic [1:0] CFG_STEPS    = 2'd3;

    typedef struct packed {
        logic                     method;
        logic [23:0]              ratio;
        logic signed [DATA_W-1:0] boundary;
        logic [15:0]              steps;
    } cfg_t;

    // A fixed-point result together with its saturation mark.
    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     sat;
    } qres_t;

    function automatic qres_t q_clamp(input logic signed [DATA_W:0] v);
        qres_t r;
        if (v[DATA_W] != v[DATA_W-1]) begin
            r.sat = 1'b1;
            r.val = v[DATA_W] ? Q_MIN : Q_MAX;
        end else begin
            r.sat = 1'b0;
            r.val = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic qres_t q_add(input logic signed [DATA_W-1:0] a,
                                    input logic signed [DATA_W-1:0] b);
        return q_clamp({a[DATA_W-1], a} + {b[DATA_W-1], b});
    endfunction

    function automatic qres_t q_sub(input logic signed [DATA_W-1:0] a,
                                    input logic signed [DATA_W-1:0] b);
        return q_clamp({a[DATA_W-1], a} - {b[DATA_W-1], b});
    endfunction

    // Rounds an exact Q32.32 product to Q16.16, nearest with ties away from zero.
    function automatic qres_t q_round(input logic signed [2*DATA_W-1:0] p);
        logic [2*DATA_W-1:0] mg;
        logic [47:0]         m;
        qres_t               r;
        mg = p[2*DATA_W-1] ? 64'(-p) : 64'(p);
        m  = 48'((mg + 64'h8000) >> 16);
        r.sat = 1'b0;
        if (!p[2*DATA_W-1]) begin
            if (m > 48'h7FFF_FFFF) begin
                r.sat = 1'b1;
                r.val = Q_MAX;
            end else begin
                r.val = m[DATA_W-1:0];
            end
        end else begin
            if (m > 48'h8000_0000) begin
                r.sat = 1'b1;
                r.val = Q_MIN;
            end else begin
                r.val = -m[DATA_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/ihts_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ihts_ram (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [ihts_pkg::ADDR_W-1:0]      waddr,
    input  wire logic [ihts_pkg::DATA_W-1:0]      wdata,
    input  wire logic [ihts_pkg::ADDR_W-1:0]      raddr,
    output logic      [ihts_pkg::DATA_W-1:0]      rdata
);

    logic [ihts_pkg::DATA_W-1:0] mem [ihts_pkg::MAX_POINTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/ihts_div.sv
// Iterative Q16.16 divider, one quotient bit per cycle, rounded and saturating.
`timescale 1ns / 1ps
`default_nettype none

module ihts_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [ihts_pkg::DATA_W-1:0] a,
    input  wire logic signed [ihts_pkg::DATA_W-1:0] b,
    output logic                                    done,
    output logic signed [ihts_pkg::DATA_W-1:0]      q,
    output logic                                    sat
);

    localparam int DIV_STEPS = 48;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    logic              busy_reg;
    logic              fin_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [47:0]       num_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       den_reg;
    logic              neg_reg;
    logic signed [31:0] q_reg;
    logic              sat_reg;

    logic [32:0]       trial;
    logic              ge;
    logic [31:0]       rem_next;
    logic [31:0]       ua;
    logic [31:0]       ub;
    ihts_pkg::qres_t   fin_q;

    always_comb
    begin
        trial    = {rem_reg, num_reg[47]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
        ua       = a[31] ? 32'(-a) : 32'(a);
        ub       = b[31] ? 32'(-b) : 32'(b);
        fin_q.sat = 1'b0;
        if (!neg_reg)
        begin
            if (num_reg > 48'h7FFF_FFFF)
            begin
                fin_q.sat = 1'b1;
                fin_q.val = ihts_pkg::Q_MAX;
            end
            else
            begin
                fin_q.val = num_reg[31:0];
            end
        end
        else
        begin
            if (num_reg > 48'h8000_0000)
            begin
                fin_q.sat = 1'b1;
                fin_q.val = ihts_pkg::Q_MIN;
            end
            else
            begin
                fin_q.val = -num_reg[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (b == 32'sd0)
                begin
                    // Zero divisor clamps toward the sign of the dividend.
                    sat_reg  <= 1'b1;
                    done_reg <= 1'b1;
                    if (a[31])
                    begin
                        q_reg <= ihts_pkg::Q_MIN;
                    end
                    else if (a != 32'sd0)
                    begin
                        q_reg <= ihts_pkg::Q_MAX;
                    end
                    else
                    begin
                        q_reg <= 32'sd0;
                    end
                end
                else
                begin
                    num_reg  <= 48'({ua, 16'b0}) + 48'(ub[31:1]);
                    rem_reg  <= '0;
                    den_reg  <= ub;
                    neg_reg  <= a[31] ^ b[31];
                    cnt_reg  <= STEP_W'(DIV_STEPS);
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                num_reg <= {num_reg[46:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
                q_reg    <= fin_q.val;
                sat_reg  <= fin_q.sat;
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;
    assign sat  = sat_reg;

endmodule

`default_nettype wire

### sv/ihts_core.sv
// Sequencer of the solver: grid load, right-hand side, Thomas sweeps and emission.
`timescale 1ns / 1ps
`default_nettype none

module ihts_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ihts_pkg::cfg_t                cfg,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ihts_pkg::DATA_W-1:0]   s_tdata,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ihts_pkg::DATA_W-1:0]        m_tdata,
    output logic                               m_tlast,
    output logic [1:0]                         m_tuser
);

    localparam int AW = ihts_pkg::ADDR_W;
    localparam int CW = ihts_pkg::CNT_W;
    localparam int DW = ihts_pkg::DATA_W;

    typedef enum logic [5:0] {
        S_LOAD, S_START, S_EDGE_M, S_EDGE_R, S_W0, S_W1,
        S_CN_RD, S_CN_M1, S_CN_M2, S_CN_M3, S_CN_M4,
        S_LA_RD, S_LA_ACC, S_RHS_E, S_RHS_WR,
        S_F0, S_F0_W, S_F0_R, S_F0_D,
        S_F_M, S_F_DEN, S_F_NUM, S_F_C, S_F_CW, S_F_D, S_F_DW,
        S_B_RD, S_B_M, S_B_S, S_BND, S_BND2,
        S_E_RD, S_E_LD
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       cnt_reg;
    logic [AW-1:0]       i_reg;
    logic [AW-1:0]       e_reg;
    logic [AW-1:0]       m_reg;
    logic [15:0]         steps_reg;
    logic                short_reg;
    logic                sat_reg;
    logic signed [DW-1:0]   acc_reg;
    logic signed [2*DW-1:0] prod_reg;
    logic signed [DW-1:0]   edge_reg;
    logic signed [DW-1:0]   w0_reg;
    logic signed [DW-1:0]   w1_reg;
    logic signed [DW-1:0]   w2_reg;
    logic signed [DW-1:0]   c_prev_reg;
    logic signed [DW-1:0]   d_prev_reg;
    logic signed [DW-1:0]   den_reg;
    logic signed [DW-1:0]   g_next_reg;
    logic                out_valid_reg;
    logic [DW-1:0]       out_data_reg;
    logic                out_last_reg;
    logic                out_short_reg;
    logic                out_sat_reg;

    logic signed [DW-1:0] r32;
    logic signed [DW-1:0] ds;
    logic signed [DW-1:0] dm;
    logic signed [DW-1:0] cc;
    logic [AW-1:0]        last_i;
    logic                 s_fire;
    logic                 out_free;

    logic signed [DW-1:0] mul_a;
    logic signed [DW-1:0] mul_b;
    ihts_pkg::qres_t      mul_q;
    ihts_pkg::qres_t      sum_q;
    ihts_pkg::qres_t      edge_q;
    ihts_pkg::qres_t      den_q;
    ihts_pkg::qres_t      diff_q;

    logic                 g_we;
    logic [AW-1:0]        g_waddr;
    logic [DW-1:0]        g_wdata;
    logic [AW-1:0]        g_raddr;
    logic [DW-1:0]        g_rdata;
    logic                 c_we;
    logic [AW-1:0]        c_waddr;
    logic [DW-1:0]        c_wdata;
    logic [AW-1:0]        c_raddr;
    logic [DW-1:0]        c_rdata;
    logic                 d_we;
    logic [AW-1:0]        d_waddr;
    logic [DW-1:0]        d_wdata;
    logic [AW-1:0]        d_raddr;
    logic [DW-1:0]        d_rdata;

    logic                 div_start;
    logic signed [DW-1:0] div_a;
    logic signed [DW-1:0] div_b;
    logic                 div_done;
    logic signed [DW-1:0] div_q;
    logic                 div_sat;

    // Matrix constants follow from the configuration and never overflow.
    always_comb
    begin
        r32    = {8'b0, cfg.ratio};
        ds     = -r32;
        dm     = (cfg.method ? ihts_pkg::ONE_Q : (ihts_pkg::ONE_Q <<< 1)) + (r32 <<< 1);
        cc     = (ihts_pkg::ONE_Q <<< 1) - (r32 <<< 1);
        last_i = m_reg - 1'b1;
        s_fire = s_tvalid && s_tready;
        out_free = !out_valid_reg || m_tready;
        mul_q  = ihts_pkg::q_round(prod_reg);
        sum_q  = ihts_pkg::q_add(acc_reg, mul_q.val);
        edge_q = ihts_pkg::q_add(acc_reg, edge_reg);
        den_q  = ihts_pkg::q_sub(dm, mul_q.val);
        diff_q = ihts_pkg::q_sub(acc_reg, mul_q.val);
    end

    // Operand selection of the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_EDGE_M:
            begin
                mul_a = r32;
                mul_b = cfg.boundary;
            end
            S_CN_M1:
            begin
                mul_a = cc;
                mul_b = w1_reg;
            end
            S_CN_M2:
            begin
                mul_a = r32;
                mul_b = w2_reg;
            end
            S_CN_M3:
            begin
                mul_a = r32;
                mul_b = w0_reg;
            end
            S_F_M:
            begin
                mul_a = ds;
                mul_b = c_prev_reg;
            end
            S_F_DEN:
            begin
                mul_a = ds;
                mul_b = d_prev_reg;
            end
            S_B_M:
            begin
                mul_a = c_rdata;
                mul_b = g_next_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Operand selection of the shared divider.
    always_comb
    begin
        div_start = 1'b0;
        div_a     = ds;
        div_b     = dm;
        unique case (state_reg)
            S_F0:
            begin
                div_start = 1'b1;
                div_a     = ds;
                div_b     = dm;
            end
            S_F0_R:
            begin
                div_start = 1'b1;
                div_a     = d_rdata;
                div_b     = dm;
            end
            S_F_C:
            begin
                div_start = 1'b1;
                div_a     = ds;
                div_b     = den_reg;
            end
            S_F_D:
            begin
                div_start = 1'b1;
                div_a     = acc_reg;
                div_b     = den_reg;
            end
            default:
            begin
                div_start = 1'b0;
                div_a     = ds;
                div_b     = dm;
            end
        endcase
    end

    // Memory ports. Every access is placed in its own state, so a read never
    // meets a pending write to the same entry.
    always_comb
    begin
        g_we    = 1'b0;
        g_waddr = '0;
        g_wdata = '0;
        g_raddr = '0;
        c_we    = 1'b0;
        c_waddr = i_reg;
        c_wdata = div_q;
        c_raddr = i_reg;
        d_we    = 1'b0;
        d_waddr = i_reg;
        d_wdata = div_q;
        d_raddr = i_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                g_we    = s_fire && (cnt_reg < CW'(ihts_pkg::MAX_POINTS));
                g_waddr = cnt_reg[AW-1:0];
                g_wdata = s_tdata;
            end
            S_EDGE_R: g_raddr = '0;
            S_W0:     g_raddr = AW'(1);
            S_CN_RD:  g_raddr = i_reg + AW'(2);
            S_LA_RD:  g_raddr = i_reg + AW'(1);
            S_RHS_WR:
            begin
                d_we    = 1'b1;
                d_wdata = acc_reg;
            end
            S_F0_W:
            begin
                c_we    = div_done;
                c_waddr = '0;
                d_raddr = '0;
            end
            S_F0_D:
            begin
                d_we    = div_done;
                d_waddr = '0;
            end
            S_F_CW:   c_we = div_done;
            S_F_DW:
            begin
                d_we    = div_done;
                g_we    = div_done && (i_reg == last_i);
                g_waddr = m_reg;
                g_wdata = div_q;
            end
            S_B_S:
            begin
                g_we    = 1'b1;
                g_waddr = i_reg + AW'(1);
                g_wdata = diff_q.val;
            end
            S_BND:
            begin
                g_we    = 1'b1;
                g_waddr = '0;
                g_wdata = cfg.boundary;
            end
            S_BND2:
            begin
                g_we    = 1'b1;
                g_waddr = m_reg + AW'(1);
                g_wdata = cfg.boundary;
            end
            S_E_RD:   g_raddr = e_reg;
            default:  g_raddr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            short_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            e_reg         <= '0;
            m_reg         <= '0;
            steps_reg     <= '0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            if (out_valid_reg && m_tready && (state_reg != S_E_LD))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (s_fire)
                    begin
                        if (cnt_reg < CW'(ihts_pkg::MAX_POINTS))
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        if (s_tlast)
                        begin
                            state_reg <= S_START;
                        end
                    end
                end
                S_START:
                begin
                    sat_reg <= 1'b0;
                    e_reg   <= '0;
                    if (cnt_reg < CW'(ihts_pkg::SHORT_GRID))
                    begin
                        short_reg <= 1'b1;
                        state_reg <= S_E_RD;
                    end
                    else
                    begin
                        short_reg <= 1'b0;
                        m_reg     <= AW'(cnt_reg - CW'(2));
                        steps_reg <= (cfg.steps == 16'd0) ? 16'd1 : cfg.steps;
                        state_reg <= S_EDGE_M;
                    end
                end
                S_EDGE_M: state_reg <= S_EDGE_R;
                S_EDGE_R:
                begin
                    edge_reg  <= mul_q.val;
                    sat_reg   <= sat_reg | mul_q.sat;
                    i_reg     <= '0;
                    state_reg <= cfg.method ? S_LA_RD : S_W0;
                end
                S_W0:
                begin
                    w0_reg    <= g_rdata;
                    state_reg <= S_W1;
                end
                S_W1:
                begin
                    w1_reg    <= g_rdata;
                    state_reg <= S_CN_RD;
                end
                S_CN_RD:  state_reg <= S_CN_M1;
                S_CN_M1:
                begin
                    w2_reg    <= g_rdata;
                    state_reg <= S_CN_M2;
                end
                S_CN_M2:
                begin
                    acc_reg   <= mul_q.val;
                    sat_reg   <= sat_reg | mul_q.sat;
                    state_reg <= S_CN_M3;
                end
                S_CN_M3:
                begin
                    acc_reg   <= sum_q.val;
                    sat_reg   <= sat_reg | mul_q.sat | sum_q.sat;
                    state_reg <= S_CN_M4;
                end
                S_CN_M4:
                begin
                    acc_reg   <= sum_q.val;
                    sat_reg   <= sat_reg | mul_q.sat | sum_q.sat;
                    state_reg <= S_RHS_E;
                end
                S_LA_RD:  state_reg <= S_LA_ACC;
                S_LA_ACC:
                begin
                    acc_reg   <= g_rdata;
                    state_reg <= S_RHS_E;
                end
                S_RHS_E:
                begin
                    // Both end rows take the boundary contribution.
                    if (i_reg == '0 || i_reg == last_i)
                    begin
                        acc_reg <= edge_q.val;
                        sat_reg <= sat_reg | edge_q.sat;
                    end
                    state_reg <= S_RHS_WR;
                end
                S_RHS_WR:
                begin
                    w0_reg <= w1_reg;
                    w1_reg <= w2_reg;
                    if (i_reg == last_i)
                    begin
                        state_reg <= S_F0;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= cfg.method ? S_LA_RD : S_CN_RD;
                    end
                end
                S_F0:     state_reg <= S_F0_W;
                S_F0_W:
                begin
                    if (div_done)
                    begin
                        c_prev_reg <= div_q;
                        sat_reg    <= sat_reg | div_sat;
                        state_reg  <= S_F0_R;
                    end
                end
                S_F0_R:   state_reg <= S_F0_D;
                S_F0_D:
                begin
                    if (div_done)
                    begin
                        d_prev_reg <= div_q;
                        sat_reg    <= sat_reg | div_sat;
                        i_reg      <= AW'(1);
                        state_reg  <= S_F_M;
                    end
                end
                S_F_M:    state_reg <= S_F_DEN;
                S_F_DEN:
                begin
                    den_reg   <= den_q.val;
                    sat_reg   <= sat_reg | mul_q.sat | den_q.sat;
                    acc_reg   <= d_rdata;
                    state_reg <= S_F_NUM;
                end
                S_F_NUM:
                begin
                    acc_reg   <= diff_q.val;
                    sat_reg   <= sat_reg | mul_q.sat | diff_q.sat;
                    state_reg <= (i_reg == last_i) ? S_F_D : S_F_C;
                end
                S_F_C:    state_reg <= S_F_CW;
                S_F_CW:
                begin
                    if (div_done)
                    begin
                        c_prev_reg <= div_q;
                        sat_reg    <= sat_reg | div_sat;
                        state_reg  <= S_F_D;
                    end
                end
                S_F_D:    state_reg <= S_F_DW;
                S_F_DW:
                begin
                    if (div_done)
                    begin
                        d_prev_reg <= div_q;
                        sat_reg    <= sat_reg | div_sat;
                        if (i_reg == last_i)
                        begin
                            g_next_reg <= div_q;
                            i_reg      <= m_reg - AW'(2);
                            state_reg  <= S_B_RD;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_F_M;
                        end
                    end
                end
                S_B_RD:   state_reg <= S_B_M;
                S_B_M:
                begin
                    acc_reg   <= d_rdata;
                    state_reg <= S_B_S;
                end
                S_B_S:
                begin
                    g_next_reg <= diff_q.val;
                    sat_reg    <= sat_reg | mul_q.sat | diff_q.sat;
                    if (i_reg == '0)
                    begin
                        state_reg <= S_BND;
                    end
                    else
                    begin
                        i_reg     <= i_reg - 1'b1;
                        state_reg <= S_B_RD;
                    end
                end
                S_BND:    state_reg <= S_BND2;
                S_BND2:
                begin
                    if (steps_reg == 16'd1)
                    begin
                        e_reg     <= '0;
                        state_reg <= S_E_RD;
                    end
                    else
                    begin
                        steps_reg <= steps_reg - 1'b1;
                        state_reg <= S_EDGE_M;
                    end
                end
                S_E_RD:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_E_LD;
                    end
                end
                S_E_LD:
                begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= g_rdata;
                    out_last_reg  <= (e_reg == AW'(cnt_reg - 1'b1));
                    out_short_reg <= short_reg;
                    out_sat_reg   <= sat_reg & ~short_reg;
                    if (e_reg == AW'(cnt_reg - 1'b1))
                    begin
                        cnt_reg   <= '0;
                        sat_reg   <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                    else
                    begin
                        e_reg     <= e_reg + 1'b1;
                        state_reg <= S_E_RD;
                    end
                end
                default:  state_reg <= S_LOAD;
            endcase
        end
    end

    ihts_ram u_grid (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    ihts_ram u_coeff (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    ihts_ram u_rhs (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    ihts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (div_a),
        .b     (div_b),
        .done  (div_done),
        .q     (div_q),
        .sat   (div_sat)
    );

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_sat_reg, out_short_reg};

endmodule

`default_nettype wire

### sv/implicit_heat_tridiagonal_solver_top.sv
// Top level of the implicit 1D heat solver: configuration registers and the solver core.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The input stream carries one grid point per beat, boundaries included, and
// s_tlast marks the final point. Points load at one per cycle into the grid
// memory; points beyond 64 are dropped, but the last beat still starts the solve.
// While solving and emitting, s_tready is low. Each time step reads and
// writes three on-chip memories through one shared multiplier and one shared
// divider that yields a quotient bit per cycle. A step's time is dominated by
// the divisions of the forward sweep, two per row but one in the last row,
// and the fully implicit scheme builds each right-hand-side entry in fewer
// states; step_count steps run per grid. The grid then leaves on the output
// stream, one point per beat. m_tuser carries the short-grid and saturation
// flags; grids under four points come back unchanged. A stalled receiver
// simply holds the output register; the final beat sits in that register
// while the block already accepts the next grid.
// Reset clears all control state and returns the registers to method 0,
// ratio 0.5, boundary 0 and one step; memory contents are left as they are.
// Configuration writes are taken every cycle and must happen while idle.

module implicit_heat_tridiagonal_solver_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] temperature
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] result_temp
    output logic             m_tlast,
    output logic [1:0]       m_tuser    // [0] too_short, [1] saturated
);

    ihts_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    // Register writes land directly; the register index picks the field.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.method   <= 1'b0;
            cfg_reg.ratio    <= 24'd32768;
            cfg_reg.boundary <= 32'sd0;
            cfg_reg.steps    <= 16'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ihts_pkg::CFG_METHOD:   cfg_reg.method   <= cfg_data[0];
                ihts_pkg::CFG_RATIO:    cfg_reg.ratio    <= cfg_data[23:0];
                ihts_pkg::CFG_BOUNDARY: cfg_reg.boundary <= cfg_data;
                ihts_pkg::CFG_STEPS:    cfg_reg.steps    <= cfg_data[15:0];
                default:                cfg_reg.steps    <= cfg_reg.steps;
            endcase
        end
    end

    ihts_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // The last point of a grid closes the input until the grid is emitted.
    a_close_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after the last point");

    // While a grid is leaving, no new point is taken.
    a_no_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !s_tready)
        else $error("input open in the middle of an emitted grid");

    // Nothing follows the final beat of a grid in the next cycle.
    a_gap_after_grid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("output beat right after the end of a grid");

    // A short grid is never solved, so it cannot report saturation.
    a_short_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("short grid reports saturation");

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for the implicit heat solver: directed grids, then random grids.
`timescale 1ns / 1ps

module tb;
    import ihts_pkg::*;

    // Long enough for the slowest run of this stimulus, several times over.
    localparam int CYCLE_LIMIT = 4000000;

    // Drain cycles after the last result. Also the settle time before a register write.
    localparam int SETTLE = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_METHOD;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    implicit_heat_tridiagonal_solver_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always #6 clk = ~clk;

    // One expected output beat of the solved grid.
    typedef struct {
        logic [31:0] temp;
        bit          last;
        bit          short_grid;
        bit          sat;
    } point_t;

    point_t solved_points[$];
    int     errors = 0;
    int     cycles = 0;
    bit     quiet_mode = 1'b0;   // When set, neither side idles.

    // Predictor state: its own register copy, grid and sweep memories.
    bit                 pm_method = 1'b0;
    logic [23:0]        pm_ratio = 24'd32768;
    logic signed [31:0] pm_boundary = '0;
    logic [15:0]        pm_steps = 16'd1;
    logic signed [31:0] pm_grid [MAX_POINTS];
    logic signed [31:0] pm_coef [MAX_POINTS];
    logic signed [31:0] pm_rhs [MAX_POINTS];
    int                 pm_count = 0;
    bit                 pm_sat = 1'b0;

    // Clamp to the signed 32-bit range and note the saturation.
    function automatic logic signed [31:0] clamp_q(input longint v);
        if (v > 64'sd2147483647)
        begin
            pm_sat = 1'b1;
            return Q_MAX;
        end
        if (v < -64'sd2147483648)
        begin
            pm_sat = 1'b1;
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] add_q(input logic signed [31:0] a, b);
        return clamp_q(longint'(a) + longint'(b));
    endfunction

    function automatic logic signed [31:0] sub_q(input logic signed [31:0] a, b);
        return clamp_q(longint'(a) - longint'(b));
    endfunction

    // Exact product, rounded to nearest with ties away from zero.
    function automatic logic signed [31:0] mul_q(input logic signed [31:0] a, b);
        longint p;
        longint m;
        p = longint'(a) * longint'(b);
        m = ((p < 0 ? -p : p) + 64'sd32768) >>> 16;
        return clamp_q(p < 0 ? -m : m);
    endfunction

    function automatic logic signed [31:0] div_q(input logic signed [31:0] a, b);
        longint ua;
        longint ub;
        longint q;
        if (b == 0)
        begin
            pm_sat = 1'b1;
            return a > 0 ? Q_MAX : (a < 0 ? Q_MIN : 32'sd0);
        end
        ua = a < 0 ? -longint'(a) : longint'(a);
        ub = b < 0 ? -longint'(b) : longint'(b);
        q = ((ua <<< 16) + ub / 2) / ub;
        return clamp_q(((a < 0) != (b < 0)) ? -q : q);
    endfunction

    // One implicit time step over n points, then both ends pinned to the boundary.
    task automatic advance_step(input int n);
        int m;
        logic signed [31:0] r, ds, dm, cc, edge_term, den, v;
        m = n - 2;
        r = $signed({8'd0, pm_ratio});
        ds = -r;
        dm = pm_method ? ONE_Q + 2 * r : 2 * ONE_Q + 2 * r;
        cc = 2 * (ONE_Q - r);
        edge_term = mul_q(r, pm_boundary);
        for (int i = 0; i < m; i++)
        begin
            if (pm_method)
            begin
                pm_rhs[i] = pm_grid[i + 1];
            end
            else
            begin
                v = mul_q(cc, pm_grid[i + 1]);
                v = add_q(v, mul_q(r, pm_grid[i + 2]));
                pm_rhs[i] = add_q(v, mul_q(r, pm_grid[i]));
            end
        end
        pm_rhs[0] = add_q(pm_rhs[0], edge_term);
        pm_rhs[m - 1] = add_q(pm_rhs[m - 1], edge_term);
        pm_coef[0] = div_q(ds, dm);
        pm_rhs[0] = div_q(pm_rhs[0], dm);
        for (int i = 1; i < m; i++)
        begin
            den = sub_q(dm, mul_q(ds, pm_coef[i - 1]));
            if (i < m - 1)
                pm_coef[i] = div_q(ds, den);
            pm_rhs[i] = div_q(sub_q(pm_rhs[i], mul_q(ds, pm_rhs[i - 1])), den);
        end
        pm_grid[m] = pm_rhs[m - 1];
        for (int i = m - 2; i >= 0; i--)
            pm_grid[i + 1] = sub_q(pm_rhs[i], mul_q(pm_coef[i], pm_grid[i + 2]));
        pm_grid[0] = pm_boundary;
        pm_grid[n - 1] = pm_boundary;
    endtask

    // Takes one accepted point; the final one solves the grid and queues its output.
    task automatic absorb_point(input logic [31:0] temp, input bit last);
        int  steps;
        bit  short_grid;
        point_t pt;
        if (pm_count < MAX_POINTS)
        begin
            pm_grid[pm_count] = temp;
            pm_count++;
        end
        if (!last)
            return;
        short_grid = pm_count < SHORT_GRID;
        pm_sat = 1'b0;
        if (!short_grid)
        begin
            steps = pm_steps == 0 ? 1 : int'(pm_steps);
            for (int k = 0; k < steps; k++)
                advance_step(pm_count);
        end
        for (int k = 0; k < pm_count; k++)
        begin
            pt.temp = pm_grid[k];
            pt.last = (k + 1 == pm_count);
            pt.short_grid = short_grid;
            pt.sat = short_grid ? 1'b0 : pm_sat;
            solved_points.insert(solved_points.size(), pt);
        end
        pm_count = 0;
        pm_sat = 1'b0;
    endtask

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int roll;
        if (quiet_mode)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one grid point; called at a falling edge and returns at one.
    // tvalid stays high when the next beat follows with no gap.
    task automatic send_point(input logic [31:0] temp, input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= temp;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_point(temp, last);
        @(negedge clk);
    endtask

    // Holds the sender off until every expected beat has left and the block settles.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (solved_points.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            CFG_METHOD:   pm_method = data[0];
            CFG_RATIO:    pm_ratio = data[23:0];
            CFG_BOUNDARY: pm_boundary = data;
            CFG_STEPS:    pm_steps = data[15:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_all(input bit method, input logic [23:0] ratio,
                           input logic [31:0] boundary, input logic [15:0] steps);
        wait_idle();
        write_reg(CFG_METHOD, {31'd0, method});
        write_reg(CFG_RATIO, {8'd0, ratio});
        write_reg(CFG_BOUNDARY, boundary);
        write_reg(CFG_STEPS, {16'd0, steps});
        cfg_valid <= 1'b0;
    endtask

    // A grid of n points: half anywhere in the range, half near zero in Q16.16.
    task automatic send_grid(input int n);
        for (int i = 0; i < n; i++)
            send_point($urandom_range(0, 1) ? $urandom() : 32'($signed($urandom_range(0, 2000000))
                       - 1000000), i == n - 1);
    endtask

    task automatic test_reset_defaults();
        // The registers still hold their reset values here.
        send_point(32'sd65536, 1'b0);
        send_point(32'sd131072, 1'b0);
        send_point(-32'sd65536, 1'b0);
        send_point(32'sd0, 1'b0);
        send_point(32'sd327680, 1'b1);
    endtask

    task automatic test_short_grids();
        // Short grids skip the solve, so the largest step count costs nothing here.
        set_all(1'b1, 24'hFF_FFFF, Q_MAX, 16'hFFFF);
        send_point(Q_MAX, 1'b1);
        send_point(Q_MIN, 1'b0);
        send_point(32'h1234_5678, 1'b1);
        send_point(32'hFFFF_FFFF, 1'b0);
        send_point(32'd0, 1'b0);
        send_point(32'hA5A5_5A5A, 1'b1);
    endtask

    task automatic test_extremes();
        // Zero ratio with a zero step count, which runs one step.
        set_all(1'b0, 24'd0, Q_MIN, 16'd0);
        send_point(Q_MAX, 1'b0);
        send_point(Q_MIN, 1'b0);
        send_point(Q_MAX, 1'b0);
        send_point(Q_MIN, 1'b1);
        // Largest ratio: the sums overflow and saturate.
        set_all(1'b0, 24'hFF_FFFF, Q_MAX, 16'd2);
        send_point(Q_MIN, 1'b0);
        send_point(Q_MAX, 1'b0);
        send_point(Q_MAX, 1'b0);
        send_point(Q_MIN, 1'b1);
        // Fully implicit scheme.
        set_all(1'b1, 24'h01_8000, 32'sh0010_0000, 16'd3);
        send_point(32'sd0, 1'b0);
        send_point(Q_MAX, 1'b0);
        send_point(Q_MIN, 1'b0);
        send_point(32'sh0002_0000, 1'b1);
    endtask

    task automatic test_full_store();
        // Two points past the store size are dropped, the last one still starts the solve.
        set_all(1'b0, 24'h00_4000, 32'sh0001_0000, 16'd1);
        send_grid(MAX_POINTS + 2);
    endtask

    task automatic test_random();
        int sent;
        int n;
        int roll;
        logic [31:0] ratio_word;
        sent = 0;
        while (sent < 110)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                ratio_word = $urandom_range(0, 1) ? $urandom_range(0, 131072) : $urandom();
                set_all($urandom_range(0, 1), ratio_word[23:0], $urandom(),
                        16'($urandom_range(0, 3)));
                quiet_mode = $urandom_range(0, 4) == 0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 15)
                n = $urandom_range(1, 3);
            else if (roll < 95)
                n = $urandom_range(4, 10);
            else
                n = $urandom_range(11, MAX_POINTS);
            send_grid(n);
            sent += n;
            // Now and then the sender waits for the whole grid to come back.
            if ($urandom_range(0, 5) == 0)
                wait_idle();
        end
        quiet_mode = 1'b0;
    endtask

    // Receiver: random stalls of random length, with idle-free stretches.
    int hold_left = 0;
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (quiet_mode)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready <= $urandom_range(0, 99) < 70;
            hold_left <= $urandom_range(0, 9) == 0 ? $urandom_range(5, 30)
                                                   : $urandom_range(0, 2);
        end
    end

    // Each output beat is matched against the oldest expected point.
    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (solved_points.size() == 0)
            begin
                $error("unexpected beat: result_temp %h", m_tdata);
                errors++;
            end
            else
            begin
                want = solved_points.pop_front();
                if (m_tdata !== want.temp)
                begin
                    $error("result_temp expected %h actual %h", want.temp, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_out expected %b actual %b", want.last, m_tlast);
                    errors++;
                end
                if (m_tuser[0] !== want.short_grid)
                begin
                    $error("too_short expected %b actual %b", want.short_grid, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== want.sat)
                begin
                    $error("saturated expected %b actual %b", want.sat, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_short_grids();
        test_extremes();
        test_full_store();
        test_random();
        wait_idle();
        if (solved_points.size() != 0)
        begin
            $error("%0d expected beats never arrived", solved_points.size());
            errors++;
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
